>>> src/psa_pkg.sv
// shared types and constants for the pixel sample accumulator
// no dependencies
package psa_pkg;

  localparam int unsigned WSumW  = 40;
  localparam int unsigned WtW    = 32;
  localparam int unsigned FlatW  = 32;
  localparam int unsigned ColW   = 16;
  localparam int unsigned WeightW = 16;
  localparam int unsigned OutW   = 24;
  localparam int unsigned CoordW = 9;
  localparam int unsigned CfgW   = 9;
  localparam int unsigned WW     = 17;   // rounded product weight, Q2.15
  localparam int unsigned WcW    = WW + ColW;
  localparam int unsigned DivSteps = WSumW;
  localparam int unsigned DivCntW  = 6;
  localparam int unsigned RoundBias = 16384;
  localparam int unsigned WShift    = 15;

  typedef enum logic [1:0] {
    ACT_WADD = 2'd0,
    ACT_FADD = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_FETCH,
    ST_MUL,
    ST_WRITE,
    ST_DIV,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic [WSumW-1:0] wsum_r;
    logic [WSumW-1:0] wsum_g;
    logic [WSumW-1:0] wsum_b;
    logic [WtW-1:0]   wt;
    logic [FlatW-1:0] flat_r;
    logic [FlatW-1:0] flat_g;
    logic [FlatW-1:0] flat_b;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic clear_wr;
    logic lookup;
    logic round;
    logic mult;
    logic write;
    logic div_start;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic skip;
    logic is_read;
    logic div_last;
    logic out_free;
  } stat_t;

endpackage

>>> src/pixel_sample_accumulator.sv
// channel  | handshake                  | payload
// in       | in_valid_i / in_ready_o    | action, pixel_x/y, weights, colors
// out      | out_valid_o / out_ready_i  | status, red/green/blue_out
// cfg      | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// one request at a time: adds pass check, fetch, multiply and write, reads pass check, fetch,
// multiply and the 40-step restoring divider, out of bounds and unknown requests only the check,
// before the handoff to the result register, which waits until the output is free
// after reset a clearing pass writes MAX_WIDTH*MAX_HEIGHT entries, one per cycle,
// before the first request is taken; configuration writes are taken at any time
// a request can be taken while the previous result still waits on the output
// top level: controller plus datapath, depends on psa_pkg, psa_ctrl, psa_datapath
module pixel_sample_accumulator #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [psa_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    action_i,
  input  logic [psa_pkg::CoordW-1:0]    pixel_x_i,
  input  logic [psa_pkg::CoordW-1:0]    pixel_y_i,
  input  logic [psa_pkg::WeightW-1:0]   sample_weight_i,
  input  logic [psa_pkg::WeightW-1:0]   ray_weight_i,
  input  logic [psa_pkg::ColW-1:0]      red_in_i,
  input  logic [psa_pkg::ColW-1:0]      green_in_i,
  input  logic [psa_pkg::ColW-1:0]      blue_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          status_o,
  output logic [psa_pkg::OutW-1:0]      red_out_o,
  output logic [psa_pkg::OutW-1:0]      green_out_o,
  output logic [psa_pkg::OutW-1:0]      blue_out_o
);
  import psa_pkg::*;

  cmd_t   cmd;
  stat_t  stat;
  state_e state;

  assign cfg_ready_o = 1'b1;

  psa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .state_o   (state)
  );

  psa_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .action_i       (action_i),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .sample_weight_i(sample_weight_i),
    .ray_weight_i   (ray_weight_i),
    .red_in_i       (red_in_i),
    .green_in_i     (green_in_i),
    .blue_in_i      (blue_in_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .red_out_o      (red_out_o),
    .green_out_o    (green_out_o),
    .blue_out_o     (blue_out_o)
  );

`ifndef ASSERT_OFF
  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state == ST_CLEAR |-> !in_ready_o)
    else $error("request taken during clearing pass");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while busy");

  a_oob_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> red_out_o == '0 && green_out_o == '0 && blue_out_o == '0)
    else $error("out of bounds result carries color");
`endif

endmodule

>>> src/psa_ram.sv
// generic single port ram, one write and one read per cycle on the same address, registered read data
// no dependencies
module psa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/psa_ctrl.sv
// controller state machine: clearing pass, request sequencing, result handoff
// depends on psa_pkg
module psa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  psa_pkg::stat_t  stat_i,
  output psa_pkg::cmd_t   cmd_o,
  output psa_pkg::state_e state_o
);
  import psa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (stat_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat_i.skip) begin
          state_d = ST_RESULT;
        end else begin
          cmd_o.lookup = 1'b1;
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd_o.round = 1'b1;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mult = 1'b1;
        if (stat_i.is_read) begin
          cmd_o.div_start = 1'b1;
          state_d = ST_DIV;
        end else begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd_o.write = 1'b1;
        state_d = ST_RESULT;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  assign state_o = state_q;

endmodule

>>> src/psa_datapath.sv
// datapath: request registers, pixel store, multipliers, divider lanes, result register
// depends on psa_pkg and psa_ram
module psa_datapath #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  psa_pkg::cmd_t                 cmd_i,
  output psa_pkg::stat_t                stat_o,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_index_i,
  input  logic [psa_pkg::CfgW-1:0]      cfg_data_i,
  input  logic [1:0]                    action_i,
  input  logic [psa_pkg::CoordW-1:0]    pixel_x_i,
  input  logic [psa_pkg::CoordW-1:0]    pixel_y_i,
  input  logic [psa_pkg::WeightW-1:0]   sample_weight_i,
  input  logic [psa_pkg::WeightW-1:0]   ray_weight_i,
  input  logic [psa_pkg::ColW-1:0]      red_in_i,
  input  logic [psa_pkg::ColW-1:0]      green_in_i,
  input  logic [psa_pkg::ColW-1:0]      blue_in_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          status_o,
  output logic [psa_pkg::OutW-1:0]      red_out_o,
  output logic [psa_pkg::OutW-1:0]      green_out_o,
  output logic [psa_pkg::OutW-1:0]      blue_out_o
);
  import psa_pkg::*;

  localparam int unsigned Pixels = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW = (Pixels > 1) ? $clog2(Pixels) : 1;
  localparam int unsigned EntryW = $bits(entry_t);

  // configuration
  logic [CfgW-1:0] width_q, height_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgW'(256);
      height_q <= CfgW'(256);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_WIDTH) width_q <= cfg_data_i;
      else height_q <= cfg_data_i;
    end
  end

  // request registers
  action_e           act_q;
  logic [CoordW-1:0] x_q, y_q;
  logic [WeightW-1:0] sw_q, rw_q;
  logic [2:0][ColW-1:0] col_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q    <= action_e'(action_i);
      x_q      <= pixel_x_i;
      y_q      <= pixel_y_i;
      sw_q     <= sample_weight_i;
      rw_q     <= ray_weight_i;
      col_q[0] <= red_in_i;
      col_q[1] <= green_in_i;
      col_q[2] <= blue_in_i;
    end
  end

  logic oob, skip;
  logic [31:0] idx_full;
  assign oob = !(32'(x_q) < 32'(width_q) && 32'(x_q) < MAX_WIDTH &&
                 32'(y_q) < 32'(height_q) && 32'(y_q) < MAX_HEIGHT);
  assign skip = (act_q == ACT_NONE) || oob;
  assign idx_full = 32'(y_q) * MAX_WIDTH + 32'(x_q);

  // clearing pass counter
  logic [AW-1:0] clr_q;
  logic clear_last;
  assign clear_last = (32'(clr_q) == Pixels - 1);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_wr && !clear_last) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  // pixel store
  entry_t rd_entry, wr_entry;
  logic [EntryW-1:0] rdata;
  logic [AW-1:0] ram_addr;
  logic ram_we;

  assign ram_we   = cmd_i.clear_wr || cmd_i.write;
  assign ram_addr = cmd_i.clear_wr ? clr_q : idx_full[AW-1:0];
  assign rd_entry = entry_t'(rdata);

  psa_ram #(
    .WIDTH(EntryW),
    .DEPTH(Pixels)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (cmd_i.lookup),
    .addr_i (ram_addr),
    .wdata_i(cmd_i.clear_wr ? '0 : EntryW'(wr_entry)),
    .rdata_o(rdata)
  );

  // weight product, rounding, color products
  logic [2*WeightW-1:0] prod_q;
  logic [WW-1:0]        w_q;
  logic [2:0][WcW-1:0]  wc_q;
  logic [2*WeightW:0]   prod_rnd;
  assign prod_rnd = {1'b0, prod_q} + (2*WeightW+1)'(RoundBias);

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) prod_q <= sw_q * rw_q;
    if (cmd_i.round)  w_q <= prod_rnd[WShift +: WW];
    if (cmd_i.mult) begin
      for (int i = 0; i < 3; i++) begin
        wc_q[i] <= WcW'(w_q) * WcW'(col_q[i]);
      end
    end
  end

  // saturating updates
  logic [2:0][WSumW-1:0] wsum_old;
  logic [2:0][FlatW-1:0] flat_old;
  logic [2:0][WSumW:0]   wsum_add;
  logic [2:0][FlatW:0]   flat_add;
  logic [2:0][WSumW-1:0] wsum_new;
  logic [2:0][FlatW-1:0] flat_new;
  logic [WtW:0]          wt_add;

  assign wsum_old = {rd_entry.wsum_b, rd_entry.wsum_g, rd_entry.wsum_r};
  assign flat_old = {rd_entry.flat_b, rd_entry.flat_g, rd_entry.flat_r};
  assign wt_add   = {1'b0, rd_entry.wt} + (WtW+1)'(w_q);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wsum_add[i] = {1'b0, wsum_old[i]} + (WSumW+1)'(wc_q[i]);
      flat_add[i] = {1'b0, flat_old[i]} + (FlatW+1)'(col_q[i]);
      wsum_new[i] = wsum_add[i][WSumW] ? '1 : wsum_add[i][WSumW-1:0];
      flat_new[i] = flat_add[i][FlatW] ? '1 : flat_add[i][FlatW-1:0];
    end
    wr_entry = rd_entry;
    if (act_q == ACT_WADD) begin
      wr_entry.wsum_r = wsum_new[0];
      wr_entry.wsum_g = wsum_new[1];
      wr_entry.wsum_b = wsum_new[2];
      wr_entry.wt     = wt_add[WtW] ? '1 : wt_add[WtW-1:0];
    end else begin
      wr_entry.flat_r = flat_new[0];
      wr_entry.flat_g = flat_new[1];
      wr_entry.flat_b = flat_new[2];
    end
  end

  // restoring divider, one quotient bit per lane each cycle
  logic [2:0][WSumW-1:0] dvd_q;
  logic [2:0][WtW-1:0]   rem_q;
  logic [DivCntW-1:0]    div_cnt_q;
  logic                  div_last;
  assign div_last = (div_cnt_q == DivCntW'(DivSteps - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvd_q     <= wsum_old;
      rem_q     <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + DivCntW'(1);
      for (int i = 0; i < 3; i++) begin
        if ({rem_q[i], dvd_q[i][WSumW-1]} >= {1'b0, rd_entry.wt}) begin
          rem_q[i] <= WtW'({rem_q[i], dvd_q[i][WSumW-1]} - {1'b0, rd_entry.wt});
          dvd_q[i] <= {dvd_q[i][WSumW-2:0], 1'b1};
        end else begin
          rem_q[i] <= {rem_q[i][WtW-2:0], dvd_q[i][WSumW-1]};
          dvd_q[i] <= {dvd_q[i][WSumW-2:0], 1'b0};
        end
      end
    end
  end

  // resolve and result register
  logic [2:0][WSumW:0] res_sum;
  logic [2:0][OutW-1:0] res_col;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res_sum[i] = (WSumW+1)'(flat_old[i]) +
                   ((rd_entry.wt != '0) ? (WSumW+1)'(dvd_q[i]) : '0);
      res_col[i] = (res_sum[i] > (WSumW+1)'({OutW{1'b1}})) ? '1 : res_sum[i][OutW-1:0];
    end
  end

  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  logic                 status_q;
  logic [2:0][OutW-1:0] out_col_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_q  <= (act_q != ACT_NONE) && oob;
      out_col_q <= (!skip && act_q == ACT_READ) ? res_col : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign red_out_o   = out_col_q[0];
  assign green_out_o = out_col_q[1];
  assign blue_out_o  = out_col_q[2];

  assign stat_o.clear_last = clear_last;
  assign stat_o.skip       = skip;
  assign stat_o.is_read    = (act_q == ACT_READ);
  assign stat_o.div_last   = div_last;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

endmodule
